/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the intersection unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RTI_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ray triangle unit assertion failed");
`define RTI_ASSERT_NEVER(lbl, cond) `RTI_ASSERT(lbl, !(cond))
`else
`define RTI_ASSERT(lbl, prop)
`define RTI_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* design/rti_pkg.sv */
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Widths, constants and helpers shared by the intersection unit and its divider.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_FRAC_BITS = 10;
    localparam int PROD_SHIFT      = 10;
    localparam int CRD_W           = 21;
    localparam int REG_W           = 3 * CRD_W;
    localparam int NEAR_W          = 31;
    localparam int BARY_W          = 17;
    localparam int IN_W            = 160;
    localparam int OUT_W           = 72;

    // Divider: numerator and denominator width, quotient bits, remainder width.
    localparam int DIV_W   = 60;
    localparam int DIV_QW  = NEAR_W;
    localparam int REM_W   = DIV_W + 16;
    localparam int CMP_W   = DIV_W + DIV_QW;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam logic [NEAR_W-1:0] NEAR_MAX = {NEAR_W{1'b1}};
    localparam logic [63:0] EPS_LIMIT =
        ((64'd1 << (3 * COORD_FRAC_BITS - PROD_SHIFT)) + 64'd9999) / 64'd10000;

    typedef enum logic [1:0] {
        CFG_VERTEX_A    = 2'd0,
        CFG_VERTEX_B    = 2'd1,
        CFG_VERTEX_C    = 2'd2,
        CFG_FACE_NORMAL = 2'd3
    } cfg_idx_t;

    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic signed [CRD_W:0]   edge_t;

    typedef struct packed {
        logic              miss;
        logic [NEAR_W-1:0] nearest;
    } side_t;

    function automatic crd_t crd_field(input logic [REG_W-1:0] r, input int i);
        crd_field = r[i*CRD_W +: CRD_W];
    endfunction

endpackage

/* design/ray_triangle_intersect_unit.sv */
// ----------------------------------------------------------------------------
// Ray/triangle intersection unit
// Two-sided Moller-Trumbore test in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one ray request per clock while it is not stalled and returns
// one result per request, in order. A result passes through nine arithmetic
// stages, the first of them loaded on the accepting edge, a 32-stage
// divider and the output register, where it can be taken at the next edge.
// The divider checks for saturation in its first stage and then resolves one
// of 31 quotient bits in each following stage. The whole pipeline advances
// together: it stalls only while a result sits in the output register and the
// downstream side is not ready. The user must write triangle vertices and the
// face normal through the configuration channel only while the unit is idle;
// the unit does not enforce this. The configuration channel is always ready.
`include "assert_macros.svh"

module ray_triangle_intersect_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [rti_pkg::REG_W-1:0]   cfg_data,
    // Ray requests: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    // (21 bits each), nearest_in (31 bits), then three zero bits.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rti_pkg::IN_W-1:0]    s_tdata,
    // Results: hit (1), nearest_out (31), bary_u (17), bary_v (17), six zero bits.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rti_pkg::OUT_W-1:0]   m_tdata
);
    import rti_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [REG_W-1:0] va_reg, vb_reg, vc_reg, vn_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
            vn_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_VERTEX_A:    va_reg <= cfg_data;
                CFG_VERTEX_B:    vb_reg <= cfg_data;
                CFG_VERTEX_C:    vc_reg <= cfg_data;
                CFG_FACE_NORMAL: vn_reg <= cfg_data;
                default:         va_reg <= va_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves when the output can move.
    // ------------------------------------------------------------------
    logic                en;
    logic [9:1]          v_reg;
    logic [DIV_LAT-1:0]  vd_reg;
    logic                out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[8:1], s_tvalid};
            vd_reg        <= {vd_reg[DIV_LAT-2:0], v_reg[9]};
            out_valid_reg <= vd_reg[DIV_LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, edges, origin offset, normal products.
    // ------------------------------------------------------------------
    crd_t                    org[3], dirv[3], ca[3], cb[3], cc[3], cn[3];
    edge_t                   s1_dir_reg[3], s1_e1_reg[3], s1_e2_reg[3], s1_tp_reg[3];
    logic signed [41:0]      s1_nd_reg[3];
    logic [NEAR_W-1:0]       s1_near_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            org[i]  = s_tdata[i*CRD_W +: CRD_W];
            dirv[i] = s_tdata[(i+3)*CRD_W +: CRD_W];
            ca[i]   = crd_field(va_reg, i);
            cb[i]   = crd_field(vb_reg, i);
            cc[i]   = crd_field(vc_reg, i);
            cn[i]   = crd_field(vn_reg, i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_dir_reg[i] <= edge_t'(dirv[i]);
                s1_e1_reg[i]  <= edge_t'(cb[i]) - edge_t'(ca[i]);
                s1_e2_reg[i]  <= edge_t'(cc[i]) - edge_t'(ca[i]);
                s1_tp_reg[i]  <= edge_t'(org[i]) - edge_t'(ca[i]);
                s1_nd_reg[i]  <= 42'(cn[i]) * 42'(dirv[i]);
            end
            s1_near_reg <= s_tdata[6*CRD_W +: NEAR_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: parallel test, products of P = dir x E2.
    // ------------------------------------------------------------------
    logic signed [43:0]  nd_sum;
    edge_t               s2_dir_reg[3], s2_e1_reg[3], s2_e2_reg[3], s2_tp_reg[3];
    logic signed [42:0]  s2_pm_reg[6];
    logic                s2_miss_reg;
    logic [NEAR_W-1:0]   s2_near_reg;

    assign nd_sum = 44'(s1_nd_reg[0]) + 44'(s1_nd_reg[1]) + 44'(s1_nd_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_dir_reg   <= s1_dir_reg;
            s2_e1_reg    <= s1_e1_reg;
            s2_e2_reg    <= s1_e2_reg;
            s2_tp_reg    <= s1_tp_reg;
            s2_near_reg  <= s1_near_reg;
            s2_miss_reg  <= nd_sum == 44'sd0;
            s2_pm_reg[0] <= 43'(s1_dir_reg[1]) * 43'(s1_e2_reg[2]);
            s2_pm_reg[1] <= 43'(s1_dir_reg[2]) * 43'(s1_e2_reg[1]);
            s2_pm_reg[2] <= 43'(s1_dir_reg[2]) * 43'(s1_e2_reg[0]);
            s2_pm_reg[3] <= 43'(s1_dir_reg[0]) * 43'(s1_e2_reg[2]);
            s2_pm_reg[4] <= 43'(s1_dir_reg[0]) * 43'(s1_e2_reg[1]);
            s2_pm_reg[5] <= 43'(s1_dir_reg[1]) * 43'(s1_e2_reg[0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: P components, floor-shifted.
    // ------------------------------------------------------------------
    logic signed [43:0]  pdiff[3];
    logic signed [33:0]  s3_p_reg[3];
    edge_t               s3_dir_reg[3], s3_e1_reg[3], s3_e2_reg[3], s3_tp_reg[3];
    logic                s3_miss_reg;
    logic [NEAR_W-1:0]   s3_near_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pdiff[i] = 44'(s2_pm_reg[2*i]) - 44'(s2_pm_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_p_reg[i] <= 34'(pdiff[i] >>> PROD_SHIFT);
            end
            s3_dir_reg  <= s2_dir_reg;
            s3_e1_reg   <= s2_e1_reg;
            s3_e2_reg   <= s2_e2_reg;
            s3_tp_reg   <= s2_tp_reg;
            s3_miss_reg <= s2_miss_reg;
            s3_near_reg <= s2_near_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: determinant products E1 . P.
    // ------------------------------------------------------------------
    logic signed [55:0]  s4_dm_reg[3];
    logic signed [33:0]  s4_p_reg[3];
    edge_t               s4_dir_reg[3], s4_e1_reg[3], s4_e2_reg[3], s4_tp_reg[3];
    logic                s4_miss_reg;
    logic [NEAR_W-1:0]   s4_near_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_dm_reg[i] <= 56'(s3_e1_reg[i]) * 56'(s3_p_reg[i]);
            end
            s4_p_reg    <= s3_p_reg;
            s4_dir_reg  <= s3_dir_reg;
            s4_e1_reg   <= s3_e1_reg;
            s4_e2_reg   <= s3_e2_reg;
            s4_tp_reg   <= s3_tp_reg;
            s4_miss_reg <= s3_miss_reg;
            s4_near_reg <= s3_near_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: determinant sign, T orientation, small determinant test.
    // ------------------------------------------------------------------
    logic signed [57:0]  det_sum;
    logic signed [57:0]  det_abs;
    logic                det_pos;
    logic signed [57:0]  s5_det_reg;
    logic signed [33:0]  s5_p_reg[3];
    edge_t               s5_dir_reg[3], s5_e1_reg[3], s5_e2_reg[3], s5_t_reg[3];
    logic                s5_miss_reg;
    logic [NEAR_W-1:0]   s5_near_reg;

    assign det_sum = 58'(s4_dm_reg[0]) + 58'(s4_dm_reg[1]) + 58'(s4_dm_reg[2]);
    assign det_pos = det_sum > 58'sd0;
    assign det_abs = det_pos ? det_sum : -det_sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_t_reg[i] <= det_pos ? s4_tp_reg[i] : -s4_tp_reg[i];
            end
            s5_det_reg  <= det_abs;
            s5_miss_reg <= s4_miss_reg || (64'(unsigned'(det_abs)) < EPS_LIMIT);
            s5_p_reg    <= s4_p_reg;
            s5_dir_reg  <= s4_dir_reg;
            s5_e1_reg   <= s4_e1_reg;
            s5_e2_reg   <= s4_e2_reg;
            s5_near_reg <= s4_near_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: products of u = T . P and Q = T x E1.
    // ------------------------------------------------------------------
    logic signed [55:0]  s6_um_reg[3];
    logic signed [43:0]  s6_qm_reg[6];
    logic signed [57:0]  s6_det_reg;
    edge_t               s6_dir_reg[3], s6_e2_reg[3];
    logic                s6_miss_reg;
    logic [NEAR_W-1:0]   s6_near_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_um_reg[i] <= 56'(s5_t_reg[i]) * 56'(s5_p_reg[i]);
            end
            s6_qm_reg[0] <= 44'(s5_t_reg[1]) * 44'(s5_e1_reg[2]);
            s6_qm_reg[1] <= 44'(s5_t_reg[2]) * 44'(s5_e1_reg[1]);
            s6_qm_reg[2] <= 44'(s5_t_reg[2]) * 44'(s5_e1_reg[0]);
            s6_qm_reg[3] <= 44'(s5_t_reg[0]) * 44'(s5_e1_reg[2]);
            s6_qm_reg[4] <= 44'(s5_t_reg[0]) * 44'(s5_e1_reg[1]);
            s6_qm_reg[5] <= 44'(s5_t_reg[1]) * 44'(s5_e1_reg[0]);
            s6_det_reg   <= s5_det_reg;
            s6_dir_reg   <= s5_dir_reg;
            s6_e2_reg    <= s5_e2_reg;
            s6_miss_reg  <= s5_miss_reg;
            s6_near_reg  <= s5_near_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: u and its range test, Q components floor-shifted.
    // ------------------------------------------------------------------
    logic signed [57:0]  u_sum;
    logic signed [44:0]  qdiff[3];
    logic signed [57:0]  s7_u_reg;
    logic signed [34:0]  s7_q_reg[3];
    logic signed [57:0]  s7_det_reg;
    edge_t               s7_dir_reg[3], s7_e2_reg[3];
    logic                s7_miss_reg;
    logic [NEAR_W-1:0]   s7_near_reg;

    assign u_sum = 58'(s6_um_reg[0]) + 58'(s6_um_reg[1]) + 58'(s6_um_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qdiff[i] = 45'(s6_qm_reg[2*i]) - 45'(s6_qm_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_q_reg[i] <= 35'(qdiff[i] >>> PROD_SHIFT);
            end
            s7_u_reg    <= u_sum;
            s7_miss_reg <= s6_miss_reg || (u_sum < 58'sd0) || (u_sum > s6_det_reg);
            s7_det_reg  <= s6_det_reg;
            s7_dir_reg  <= s6_dir_reg;
            s7_e2_reg   <= s6_e2_reg;
            s7_near_reg <= s6_near_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: products of v = dir . Q and tn = E2 . Q.
    // ------------------------------------------------------------------
    logic signed [55:0]  s8_vm_reg[3];
    logic signed [56:0]  s8_tm_reg[3];
    logic signed [57:0]  s8_u_reg;
    logic signed [57:0]  s8_det_reg;
    logic                s8_miss_reg;
    logic [NEAR_W-1:0]   s8_near_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s8_vm_reg[i] <= 56'(s7_dir_reg[i]) * 56'(s7_q_reg[i]);
                s8_tm_reg[i] <= 57'(s7_e2_reg[i]) * 57'(s7_q_reg[i]);
            end
            s8_u_reg    <= s7_u_reg;
            s8_det_reg  <= s7_det_reg;
            s8_miss_reg <= s7_miss_reg;
            s8_near_reg <= s7_near_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: v and tn, remaining rejection tests, divider operands.
    // ------------------------------------------------------------------
    logic signed [57:0]  v_sum;
    logic signed [58:0]  tn_sum;
    logic signed [58:0]  uv_sum;
    logic [DIV_W-1:0]    s9_tn_reg, s9_u_reg, s9_v_reg, s9_det_reg;
    side_t               s9_side_reg;

    assign v_sum  = 58'(s8_vm_reg[0]) + 58'(s8_vm_reg[1]) + 58'(s8_vm_reg[2]);
    assign tn_sum = 59'(s8_tm_reg[0]) + 59'(s8_tm_reg[1]) + 59'(s8_tm_reg[2]);
    assign uv_sum = 59'(s8_u_reg) + 59'(v_sum);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_tn_reg  <= DIV_W'(tn_sum);
            s9_u_reg   <= DIV_W'(s8_u_reg);
            s9_v_reg   <= DIV_W'(v_sum);
            s9_det_reg <= DIV_W'(s8_det_reg);
            s9_side_reg.nearest <= s8_near_reg;
            s9_side_reg.miss    <= s8_miss_reg || (v_sum < 58'sd0)
                                   || (uv_sum > 59'(s8_det_reg)) || (tn_sum <= 59'sd0);
        end
    end

    // ------------------------------------------------------------------
    // Dividers for t, u and v, with the side data delayed alongside.
    // ------------------------------------------------------------------
    logic [NEAR_W-1:0] t_quo, u_quo, v_quo;
    side_t             side_reg[DIV_LAT];

    rti_div u_div_t (.clk(clk), .en(en), .num(s9_tn_reg), .den(s9_det_reg), .quo(t_quo));
    rti_div u_div_u (.clk(clk), .en(en), .num(s9_u_reg),  .den(s9_det_reg), .quo(u_quo));
    rti_div u_div_v (.clk(clk), .en(en), .num(s9_v_reg),  .den(s9_det_reg), .quo(v_quo));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s9_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: final distance test and result packing.
    // ------------------------------------------------------------------
    side_t              side_out;
    logic               hit_next;
    logic               hit_reg;
    logic [NEAR_W-1:0]  near_reg;
    logic [BARY_W-1:0]  bu_reg, bv_reg;

    assign side_out = side_reg[DIV_LAT-1];
    assign hit_next = !side_out.miss && (t_quo != '0) && (t_quo < side_out.nearest);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            near_reg <= hit_next ? t_quo : side_out.nearest;
            bu_reg   <= hit_next ? u_quo[BARY_W-1:0] : '0;
            bv_reg   <= hit_next ? v_quo[BARY_W-1:0] : '0;
        end
    end

    assign m_tdata = {6'd0, bv_reg, bu_reg, near_reg, hit_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `RTI_ASSERT(a_hit_nonzero_t, out_valid_reg && hit_reg |-> near_reg != '0)
    `RTI_ASSERT(a_miss_zero_bary, out_valid_reg && !hit_reg |-> bu_reg == '0 && bv_reg == '0)
    `RTI_ASSERT_NEVER(a_bary_range, out_valid_reg && hit_reg && (bu_reg > 17'd65536 || bv_reg > 17'd65536))
    `RTI_ASSERT(a_stall_holds, !en |=> $stable(v_reg) && $stable(vd_reg))

endmodule

/* design/rti_div.sv */
// ----------------------------------------------------------------------------
// Pipelined fractional divider
// Computes floor(num * 2^16 / den) one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rti_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rti_pkg::DIV_W-1:0]   num,
    input  logic [rti_pkg::DIV_W-1:0]   den,
    output logic [rti_pkg::NEAR_W-1:0]  quo
);
    import rti_pkg::*;

    logic [REM_W-1:0]  rem_reg [DIV_QW+1];
    logic [DIV_W-1:0]  den_reg [DIV_QW+1];
    logic [DIV_QW-1:0] q_reg   [DIV_QW+1];
    logic              sat_reg [DIV_QW+1];

    // The quotient overflows 15 integer bits when num >= den * 2^15.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {num, 16'd0};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= REM_W'(num) >= (REM_W'(den) << 15);
        end
    end

    for (genvar j = 1; j <= DIV_QW; j++)
    begin : g_step
        localparam int K = DIV_QW - j;
        logic [CMP_W-1:0] trial;
        logic [CMP_W-1:0] rem_ext;
        logic             ge;

        assign trial   = CMP_W'(den_reg[j-1]) << K;
        assign rem_ext = CMP_W'(rem_reg[j-1]);
        assign ge      = rem_ext >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? REM_W'(rem_ext - trial) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (DIV_QW'(ge) << K);
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    assign quo = sat_reg[DIV_QW] ? NEAR_MAX : q_reg[DIV_QW];

endmodule
